[src/length_prefix_message_deframer_defines.svh]
// assertion macros shared by the deframer modules
`ifndef LENGTH_PREFIX_MESSAGE_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIX_MESSAGE_DEFRAMER_DEFINES_SVH

// property checked on every rising edge of aclk, off while reset is held
`define LPMD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication form, antecedent then consequent on the same edge
`define LPMD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[src/lpmd_pkg.sv]
// types and constants of the length-prefixed message deframer
package lpmd_pkg;

    localparam int unsigned MAX_LEN_BYTES = 8;
    localparam int unsigned LEN_W         = 64;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned KIND_W        = 2;
    localparam int unsigned LEFT_W        = 4;
    localparam int unsigned IDX_W         = 3;

    localparam logic [BYTE_W-1:0] SHORT_FORM_LIMIT = 8'd247;
    localparam logic [LEN_W-1:0]  DEFAULT_MAX_SIZE = 64'd100 << 20;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERSIZE = 2'd2,
        KIND_SHORT    = 2'd3
    } kind_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
        kind_t             kind;
    } lpmd_result_t;

endpackage

[src/length_prefix_message_deframer.sv]
// top level of the length-prefixed message deframer
// Splits a received byte stream, one byte per item, into messages. A header
// byte up to 247 is the payload length; 248..255 announce 1..8 little-endian
// length bytes. Long-form lengths above max_message_size (cfg_wdata, written
// with cfg_we by the user only while the block is idle, which the block does
// not enforce; reset 100 MiB) give an oversize item; a zero length gives an
// empty-message item with tlast; payload bytes pass through with tlast on the
// final one. An input item with s_tuser set marks stream closure: inside a
// message it yields a short-read item, between messages nothing. After any
// error the block waits for a new header. Rate: one input item per clock
// cycle, sustained while m_tready stays high. Each item goes through an input
// register, the combinational decode in lpmd_parser, and the output register;
// a result is presented on m_tvalid once it is loaded into that register.
// s_tready depends combinationally on m_tready: while a result waits on the
// master side the block takes at most one more item into its input register
// and then holds s_tready low until the waiting result is taken.
`include "length_prefix_message_deframer_defines.svh"

module length_prefix_message_deframer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration: max_message_size
    input  logic                        cfg_we,
    input  logic [lpmd_pkg::LEN_W-1:0]  cfg_wdata,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lpmd_pkg::BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    input  logic                        s_tuser,   // [0] stream_closed
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lpmd_pkg::BYTE_W-1:0] m_tdata,   // [7:0] payload_byte
    output logic                        m_tlast,   // last
    output logic [lpmd_pkg::KIND_W-1:0] m_tuser    // [1:0] kind
);
    import lpmd_pkg::*;

    // configuration register
    logic [LEN_W-1:0]  size_limit_reg;

    // input stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_closed_reg;

    // output stage
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    kind_t             out_kind_reg;

    logic              advance;
    lpmd_result_t      result;

    // the held item is decoded once the output register can take its result
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_limit_reg <= DEFAULT_MAX_SIZE;
        end else if (cfg_we) begin
            size_limit_reg <= cfg_wdata;
        end
    end

    // input register, refilled in the same cycle it drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg   <= s_tdata;
            in_closed_reg <= s_tuser;
        end
    end

    lpmd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .rx_byte       (in_byte_reg),
        .stream_closed (in_closed_reg),
        .size_limit    (size_limit_reg),
        .result        (result)
    );

    // result register: loads on decode, empties when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            out_byte_reg <= result.payload_byte;
            out_last_reg <= result.last;
            out_kind_reg <= result.kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;

    `LPMD_ASSERT_IMP(a_non_data_zero, m_tvalid && m_tuser != KIND_DATA,
        m_tdata == '0, "non-payload item carries a data byte")
    `LPMD_ASSERT_IMP(a_error_not_last, m_tvalid && (m_tuser == KIND_OVERSIZE ||
        m_tuser == KIND_SHORT), !m_tlast, "error item marked last")
    `LPMD_ASSERT(a_held_item_kept, (in_valid_reg && !advance) |=> in_valid_reg,
        "stalled input item dropped")

endmodule

[src/lpmd_parser.sv]
// framing state and per-item decode of the deframer
`include "length_prefix_message_deframer_defines.svh"

module lpmd_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [lpmd_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        stream_closed,
    input  logic [lpmd_pkg::LEN_W-1:0]  size_limit,
    output lpmd_pkg::lpmd_result_t      result
);
    import lpmd_pkg::*;

    phase_t             phase_reg,        phase_next;
    logic [LEFT_W-1:0]  len_left_reg,     len_left_next;
    logic [IDX_W-1:0]   shift_idx_reg,    shift_idx_next;
    logic [LEN_W-1:0]   len_acc_reg,      len_acc_next;
    logic [LEN_W-1:0]   payload_left_reg, payload_left_next;

    logic [LEN_W-1:0]   acc_merged;
    logic [LEFT_W-1:0]  left_dec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            len_left_reg     <= '0;
            shift_idx_reg    <= '0;
            len_acc_reg      <= '0;
            payload_left_reg <= '0;
        end else if (step) begin
            phase_reg        <= phase_next;
            len_left_reg     <= len_left_next;
            shift_idx_reg    <= shift_idx_next;
            len_acc_reg      <= len_acc_next;
            payload_left_reg <= payload_left_next;
        end
    end

    // length byte lands in its little-endian lane
    always_comb begin
        acc_merged = len_acc_reg;
        if ({1'b0, shift_idx_reg} < (IDX_W + 1)'(MAX_LEN_BYTES)) begin
            acc_merged[shift_idx_reg*BYTE_W +: BYTE_W] = rx_byte;
        end
        left_dec = (len_left_reg != '0) ? len_left_reg - LEFT_W'(1) : len_left_reg;
    end

    always_comb begin
        phase_next        = phase_reg;
        len_left_next     = len_left_reg;
        shift_idx_next    = shift_idx_reg;
        len_acc_next      = len_acc_reg;
        payload_left_next = payload_left_reg;
        result            = '{valid: 1'b0, payload_byte: '0, last: 1'b0, kind: KIND_DATA};

        if (stream_closed) begin
            phase_next        = PH_HEADER;
            len_left_next     = '0;
            shift_idx_next    = '0;
            len_acc_next      = '0;
            payload_left_next = '0;
            if (phase_reg == PH_LENGTH || phase_reg == PH_PAYLOAD) begin
                result.valid = 1'b1;
                result.kind  = KIND_SHORT;
            end
        end else begin
            case (phase_reg)
                PH_LENGTH: begin
                    len_left_next = left_dec;
                    if (shift_idx_reg != '1) begin
                        shift_idx_next = shift_idx_reg + IDX_W'(1);
                    end
                    len_acc_next = acc_merged;
                    if (left_dec == '0) begin
                        phase_next     = PH_HEADER;
                        shift_idx_next = '0;
                        len_acc_next   = '0;
                        if (acc_merged > size_limit) begin
                            result.valid = 1'b1;
                            result.kind  = KIND_OVERSIZE;
                        end else if (acc_merged == '0) begin
                            result.valid = 1'b1;
                            result.last  = 1'b1;
                            result.kind  = KIND_EMPTY;
                        end else begin
                            phase_next        = PH_PAYLOAD;
                            payload_left_next = acc_merged;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    result.valid        = 1'b1;
                    result.payload_byte = rx_byte;
                    // decrement reaches zero from one, and zero saturates
                    if (payload_left_reg <= LEN_W'(1)) begin
                        result.last       = 1'b1;
                        phase_next        = PH_HEADER;
                        payload_left_next = '0;
                    end else begin
                        payload_left_next = payload_left_reg - LEN_W'(1);
                    end
                end
                default: begin
                    // header, also any unused phase code
                    phase_next = PH_HEADER;
                    if (rx_byte <= SHORT_FORM_LIMIT) begin
                        if (rx_byte == '0) begin
                            result.valid = 1'b1;
                            result.last  = 1'b1;
                            result.kind  = KIND_EMPTY;
                        end else begin
                            phase_next        = PH_PAYLOAD;
                            payload_left_next = LEN_W'(rx_byte);
                        end
                    end else begin
                        phase_next     = PH_LENGTH;
                        len_left_next  = LEFT_W'(rx_byte - SHORT_FORM_LIMIT);
                        shift_idx_next = '0;
                        len_acc_next   = '0;
                    end
                end
            endcase
        end
    end

    `LPMD_ASSERT_IMP(a_header_clean, phase_reg == PH_HEADER,
        payload_left_reg == '0 && len_left_reg == '0, "header phase with leftover counts")
    `LPMD_ASSERT_IMP(a_payload_nonzero, phase_reg == PH_PAYLOAD,
        payload_left_reg != '0, "payload phase with nothing left")
    `LPMD_ASSERT_IMP(a_length_nonzero, phase_reg == PH_LENGTH,
        len_left_reg != '0, "length phase with no length bytes left")

endmodule
